// ----- src/psra_pkg.sv -----
`timescale 1ns / 1ps

package psra_pkg;

   localparam int NUM_CHIPS = 4;
   localparam int CHIP_W    = 2;

   // request operation codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_RESET = 2'd2;
   localparam logic [1:0] OP_START = 2'd3;

   // frame bytes
   localparam logic [7:0] PAGE_REG_ADDR = 8'h1F;
   localparam logic [7:0] PAGE_CMD_BYTE = 8'h7E;
   localparam logic [7:0] WRITE_FLAG    = 8'h40;
   localparam logic [7:0] RESET_CMD     = 8'h80;
   localparam logic [7:0] START_CMD     = 8'hE0;
   localparam logic [7:0] IDLE_BYTE     = 8'hFF;

   typedef struct packed {
      logic [1:0]        operation;
      logic [CHIP_W-1:0] chip;
      logic [7:0]        address;
      logic [23:0]       write_data;
      logic              continuous;
   } req_type;

   typedef struct packed {
      logic [CHIP_W-1:0] select_chip;
      logic [7:0]        tx_byte;
      logic              frame_end;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAGE,
      ST_ACCESS,
      ST_SINGLE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PH_PAGE,
      PH_ACCESS,
      PH_SINGLE
   } phase_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       emit;
      phase_type  phase;
      logic [1:0] idx;
      logic       frame_end;
      logic       last;
   } cmd_type;

   // datapath to controller, valid for the request on the input ports
   typedef struct packed {
      logic ignore;
      logic access;
      logic need_page;
   } status_type;

endpackage

// ----- src/psra_ctrl.sv -----
`timescale 1ns / 1ps

module psra_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  psra_pkg::status_type status,
   output psra_pkg::cmd_type    cmd
);
   import psra_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [1:0]     cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      busy          = 1'b1;
      cmd.load      = 1'b0;
      cmd.emit      = 1'b0;
      cmd.phase     = PH_SINGLE;
      cmd.idx       = cnt_ff;
      cmd.frame_end = 1'b0;
      cmd.last      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy   = 1'b0;
            cnt_in = 2'd0;
            if (start) begin
               cmd.load = 1'b1;
               if (status.ignore) begin
                  state_in = ST_IDLE;
               end else if (!status.access) begin
                  state_in = ST_SINGLE;
               end else if (status.need_page) begin
                  state_in = ST_PAGE;
               end else begin
                  state_in = ST_ACCESS;
               end
            end
         end
         ST_PAGE: begin
            cmd.emit      = 1'b1;
            cmd.phase     = PH_PAGE;
            cmd.frame_end = (cnt_ff == 2'd3);
            cnt_in        = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            cmd.emit      = 1'b1;
            cmd.phase     = PH_ACCESS;
            cmd.frame_end = (cnt_ff == 2'd3);
            cmd.last      = (cnt_ff == 2'd3);
            cnt_in        = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         ST_SINGLE: begin
            cmd.emit      = 1'b1;
            cmd.phase     = PH_SINGLE;
            cmd.frame_end = 1'b1;
            cmd.last      = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/psra_dp.sv -----
`timescale 1ns / 1ps

module psra_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  psra_pkg::req_type    req_item,
   input  psra_pkg::cmd_type    cmd,
   output psra_pkg::status_type status,
   output logic                 rsp_strobe,
   output psra_pkg::rsp_type    rsp_item
);
   import psra_pkg::*;

   req_type    req_ff;
   logic [2:0] page_ff  [NUM_CHIPS];
   logic       known_ff [NUM_CHIPS];
   logic       strobe_ff;
   rsp_type    rsp_ff, rsp_in;

   logic       chip_ok;
   logic       in_access;
   logic [2:0] in_page;
   logic [4:0] reg_sel;
   logic [7:0] cmd_byte;

   assign chip_ok   = ({{(32-CHIP_W){1'b0}}, req_item.chip} < 32'(NUM_CHIPS));
   assign in_access = (req_item.operation inside {OP_READ, OP_WRITE});
   assign in_page   = req_item.address[7:5];

   always_comb begin
      status.ignore    = !chip_ok;
      status.access    = in_access;
      status.need_page = 1'b0;
      if (chip_ok && in_access && (req_item.address != PAGE_REG_ADDR)) begin
         status.need_page = !known_ff[req_item.chip] ||
                            (page_ff[req_item.chip] != in_page);
      end
   end

   // page cache follows the request at acceptance
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHIPS; i++) begin
            known_ff[i] <= 1'b0;
            page_ff[i]  <= 3'd0;
         end
      end else if (cmd.load && status.need_page) begin
         known_ff[req_item.chip] <= 1'b1;
         page_ff[req_item.chip]  <= in_page;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
   end

   assign reg_sel  = req_ff.address[4:0];
   assign cmd_byte = {2'b00, reg_sel, 1'b0};

   always_comb begin
      rsp_in.select_chip = req_ff.chip;
      rsp_in.frame_end   = cmd.frame_end;
      rsp_in.last        = cmd.last;
      rsp_in.tx_byte     = IDLE_BYTE;
      case (cmd.phase)
         PH_PAGE: begin
            case (cmd.idx)
               2'd0:    rsp_in.tx_byte = PAGE_CMD_BYTE;
               2'd3:    rsp_in.tx_byte = {5'd0, req_ff.address[7:5]};
               default: rsp_in.tx_byte = 8'h00;
            endcase
         end
         PH_ACCESS: begin
            if (req_ff.operation == OP_WRITE) begin
               case (cmd.idx)
                  2'd0:    rsp_in.tx_byte = cmd_byte | WRITE_FLAG;
                  2'd1:    rsp_in.tx_byte = req_ff.write_data[23:16];
                  2'd2:    rsp_in.tx_byte = req_ff.write_data[15:8];
                  default: rsp_in.tx_byte = req_ff.write_data[7:0];
               endcase
            end else begin
               rsp_in.tx_byte = (cmd.idx == 2'd0) ? cmd_byte : IDLE_BYTE;
            end
         end
         PH_SINGLE: begin
            if (req_ff.operation == OP_RESET) begin
               rsp_in.tx_byte = RESET_CMD;
            end else begin
               rsp_in.tx_byte = START_CMD | {4'd0, req_ff.continuous, 3'd0};
            end
         end
         default: rsp_in.tx_byte = IDLE_BYTE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- src/paged_spi_register_access.sv -----
`timescale 1ns / 1ps
// first byte beat appears after the request is taken, through the state register and the output register
// throughput: one byte beat per cycle while busy; a request holds busy while it sends
// its 1, 4 or 8 bytes, then start may be taken the next cycle
// reset: synchronous, clears the controller, the output strobe and the page cache
// results are strobed for one cycle; the receiver cannot stall

module paged_spi_register_access (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  psra_pkg::req_type req_item,
   output logic              rsp_strobe,
   output psra_pkg::rsp_type rsp_item
);
   import psra_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: page frame (when the cache misses), access frame, or single byte
   psra_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // datapath: request register, per-chip page cache and byte selection
   psra_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
